// File: hw/rtl/erd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the receive-ring deframer.
// No dependencies; used by the channel interfaces and the top level.

package erd_pkg;

   // Ring geometry
   localparam int unsigned RING_BYTES = 9708;
   localparam int unsigned OFFSET_W   = $clog2(RING_BYTES);
   localparam int unsigned COUNT_W    = OFFSET_W + 1;   // holds a whole frame extent
   localparam int unsigned LEN_W      = 16;              // header length field
   localparam int unsigned SUM_W      = LEN_W + 1;       // offset + length + pad
   localparam int unsigned HEADER_BYTES = 4;
   localparam int unsigned FRAME_PAD    = 7;              // header/CRC rounding term

   // Word and register widths
   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned FRAME_LEN_W   = 11;
   localparam int unsigned CAPR_BIAS_W   = 8;
   localparam int unsigned READ_PTR_W    = 16;
   localparam int unsigned CSR_INDEX_W   = 1;
   localparam int unsigned CSR_DATA_W    = FRAME_LEN_W;

   localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN_RESET = FRAME_LEN_W'(1518);
   localparam logic [CAPR_BIAS_W-1:0] CAPR_BIAS_RESET     = CAPR_BIAS_W'(16);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_LEN = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPR_BIAS     = CSR_INDEX_W'(1);

   // Header byte positions
   localparam logic [1:0] HDR_STATUS_LO = 2'd0;
   localparam logic [1:0] HDR_STATUS_HI = 2'd1;
   localparam logic [1:0] HDR_LENGTH_LO = 2'd2;
   localparam logic [1:0] HDR_LENGTH_HI = 2'd3;

   typedef enum logic [1:0] {
      KIND_PAYLOAD     = 2'd0,
      KIND_FRAME_GOOD  = 2'd1,
      KIND_FRAME_BAD   = 2'd2,
      KIND_LEN_INVALID = 2'd3
   } kind_type;

endpackage

// File: hw/rtl/erd_req_if.sv
`timescale 1ns / 1ps
// Ring byte input channel: valid/ready handshake with one ring byte per word.
// Depends on erd_pkg.

interface erd_req_if import erd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] ring_byte;

   modport source (output valid, output ring_byte, input ready);
   modport sink   (input valid, input ring_byte, output ready);
endinterface

// File: hw/rtl/erd_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one deframer result per word.
// Depends on erd_pkg.

interface erd_rsp_if import erd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   kind_type               kind;
   logic [BYTE_W-1:0]      data_byte;
   logic [FRAME_LEN_W-1:0] frame_length;
   logic [READ_PTR_W-1:0]  read_pointer;

   modport source (output valid, output kind, output data_byte, output frame_length,
                   output read_pointer, input ready);
   modport sink   (input valid, input kind, input data_byte, input frame_length,
                   input read_pointer, output ready);
endinterface

// File: hw/rtl/ethernet_rx_ring_deframer_unit.sv
`timescale 1ns / 1ps
// Receive-ring deframer: header parse, payload pass-through, frame end reporting.
// One ring byte accepted per cycle unless the result side stalls; a result is registered
// in the cycle after its byte. The result register frees in the same cycle it is taken,
// so the sustained rate is one byte per cycle unless the result side stalls.
// Synchronous active-high reset: header phase, ring offset 0, registers to defaults.

module ethernet_rx_ring_deframer_unit import erd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   erd_req_if.sink                req_chan,
   erd_rsp_if.source              rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      ST_HEADER,
      ST_GOOD,
      ST_BAD,
      ST_HALT
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   status_lsb_ff, status_lsb_in;
   logic [BYTE_W-1:0]      len_lo_ff, len_lo_in;
   logic [COUNT_W-1:0]     total_ff, total_in;
   logic [OFFSET_W-1:0]    newoff_ff, newoff_in;
   logic [OFFSET_W-1:0]    praw_ff, praw_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic [FRAME_LEN_W-1:0] max_frame_len_ff, max_frame_len_in;
   logic [CAPR_BIAS_W-1:0] capr_bias_ff, capr_bias_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [FRAME_LEN_W-1:0] rsp_flen_ff, rsp_flen_in;
   logic [READ_PTR_W-1:0]  rsp_rptr_ff, rsp_rptr_in;

   logic                   accept;
   logic [BYTE_W-1:0]      in_byte;
   logic [LEN_W-1:0]       hdr_len;
   logic [SUM_W-1:0]       end_sum;
   logic [SUM_W-1:0]       end_al;
   logic                   len_bad;
   logic [COUNT_W-1:0]     count_next;
   logic [COUNT_W-1:0]     pidx;
   logic [LEN_W-1:0]       plen_cur;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_byte        = req_chan.ring_byte;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.data_byte    = rsp_data_ff;
   assign rsp_chan.frame_length = rsp_flen_ff;
   assign rsp_chan.read_pointer = rsp_rptr_ff;

   // Frame extent from the header: end rounds (offset + len + 7) down to 4 bytes
   assign hdr_len = {in_byte, len_lo_ff};
   assign end_sum = SUM_W'(offset_ff) + SUM_W'(hdr_len) + SUM_W'(FRAME_PAD);
   assign end_al  = {end_sum[SUM_W-1:2], 2'b00};
   assign len_bad = (hdr_len == '0) || (hdr_len > LEN_W'(RING_BYTES - HEADER_BYTES));

   assign count_next = count_ff + COUNT_W'(1);
   assign pidx       = count_ff - COUNT_W'(HEADER_BYTES);
   // Cap follows the register at once, also mid-frame
   assign plen_cur   = (LEN_W'(praw_ff) < LEN_W'(max_frame_len_ff)) ?
                       LEN_W'(praw_ff) : LEN_W'(max_frame_len_ff);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      status_lsb_in    = status_lsb_ff;
      len_lo_in        = len_lo_ff;
      total_in         = total_ff;
      newoff_in        = newoff_ff;
      praw_in          = praw_ff;
      offset_in        = offset_ff;
      max_frame_len_in = max_frame_len_ff;
      capr_bias_in     = capr_bias_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in      = rsp_kind_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_flen_in      = rsp_flen_ff;
      rsp_rptr_in      = rsp_rptr_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_FRAME_LEN: max_frame_len_in = csr_wdata[FRAME_LEN_W-1:0];
            CSR_CAPR_BIAS:     capr_bias_in     = csr_wdata[CAPR_BIAS_W-1:0];
            default: ;
         endcase
      end

      if (accept && state_ff != ST_HALT) begin
         rsp_valid_in = 1'b0;
         count_in     = count_next;
         case (state_ff)
            ST_HEADER: begin
               case (count_ff[1:0])
                  HDR_STATUS_LO: status_lsb_in = in_byte[0];
                  HDR_LENGTH_LO: len_lo_in = in_byte;
                  HDR_LENGTH_HI: begin
                     if (len_bad) begin
                        state_in     = ST_HALT;
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_LEN_INVALID;
                        rsp_data_in  = '0;
                        rsp_flen_in  = '0;
                        rsp_rptr_in  = '0;
                     end else begin
                        state_in  = status_lsb_ff ? ST_GOOD : ST_BAD;
                        total_in  = COUNT_W'(end_al - SUM_W'(offset_ff));
                        newoff_in = (end_al >= SUM_W'(RING_BYTES)) ?
                                    OFFSET_W'(end_al - SUM_W'(RING_BYTES)) :
                                    OFFSET_W'(end_al);
                        praw_in   = (hdr_len > LEN_W'(HEADER_BYTES)) ?
                                    OFFSET_W'(hdr_len - LEN_W'(HEADER_BYTES)) : '0;
                     end
                  end
                  default: ;   // status high byte carries nothing we use
               endcase
            end
            ST_GOOD, ST_BAD: begin
               if (count_next >= total_ff) begin
                  // last byte of the frame: report and move to the next header
                  state_in     = ST_HEADER;
                  count_in     = '0;
                  offset_in    = newoff_ff;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = (state_ff == ST_GOOD) ? KIND_FRAME_GOOD : KIND_FRAME_BAD;
                  rsp_data_in  = '0;
                  rsp_flen_in  = (state_ff == ST_GOOD) ? FRAME_LEN_W'(plen_cur) : '0;
                  rsp_rptr_in  = READ_PTR_W'(newoff_ff) - READ_PTR_W'(capr_bias_ff);
               end else if (state_ff == ST_GOOD && LEN_W'(pidx) < plen_cur) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_PAYLOAD;
                  rsp_data_in  = in_byte;
                  rsp_flen_in  = '0;
                  rsp_rptr_in  = '0;
               end
            end
            default: ;
         endcase
      end else if (accept) begin
         rsp_valid_in = 1'b0;   // halted: bytes are dropped
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_HEADER;
         count_ff         <= '0;
         offset_ff        <= '0;
         max_frame_len_ff <= MAX_FRAME_LEN_RESET;
         capr_bias_ff     <= CAPR_BIAS_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         offset_ff        <= offset_in;
         max_frame_len_ff <= max_frame_len_in;
         capr_bias_ff     <= capr_bias_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      status_lsb_ff <= status_lsb_in;
      len_lo_ff     <= len_lo_in;
      total_ff      <= total_in;
      newoff_ff     <= newoff_in;
      praw_ff       <= praw_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_flen_ff   <= rsp_flen_in;
      rsp_rptr_ff   <= rsp_rptr_in;
   end

   // Once halted, accepted bytes never produce a result
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff == ST_HALT) |=> !rsp_valid_ff)
      else $error("result produced while halted");

   // Frame byte count stays inside the frame extent
   a_count_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GOOD || state_ff == ST_BAD) |-> (count_ff < total_ff))
      else $error("frame byte count ran past frame end");

   // A frame-done result is only visible while parsing the next header
   a_done_in_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_FRAME_GOOD || rsp_kind_ff == KIND_FRAME_BAD))
      |-> (state_ff == ST_HEADER))
      else $error("frame end reported outside header phase");

endmodule

// File: bench/ethernet_rx_ring_deframer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ethernet_rx_ring_deframer_unit: drives ring bytes with random gaps,
// predicts each result word in a scoreboard class and checks every word the block returns.
// Depends on erd_pkg, erd_req_if, erd_rsp_if and the deframer top level.

module ethernet_rx_ring_deframer_unit_tb;
   import erd_pkg::*;

   localparam int unsigned WATCHDOG_CYCLES = 5000;
   localparam int unsigned LONG_HOLD       = 250;
   localparam int unsigned PHASE_BYTES     = 100;

   typedef enum logic [1:0] {
      PARSE_HEADER,
      PARSE_GOOD,
      PARSE_BAD
   } parse_phase_type;

   typedef struct packed {
      kind_type               kind;
      logic [BYTE_W-1:0]      data_byte;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic [READ_PTR_W-1:0]  read_pointer;
   } deframe_result_type;

   class deframe_scoreboard;
      logic [FRAME_LEN_W-1:0] max_len;
      logic [CAPR_BIAS_W-1:0] bias;
      parse_phase_type        phase;
      int unsigned            byte_count;
      logic [LEN_W-1:0]       hdr_status;
      logic [LEN_W-1:0]       hdr_length;
      int unsigned            ring_off;
      bit                     halted;
      deframe_result_type     expected[$];
      int unsigned            results_checked;
      int unsigned            mismatches;

      function new();
         max_len = MAX_FRAME_LEN_RESET;
         bias = CAPR_BIAS_RESET;
         ring_off = 0;
         halted = 1'b0;
         results_checked = 0;
         mismatches = 0;
         open_frame();
      endfunction

      function void open_frame();
         phase = PARSE_HEADER;
         byte_count = 0;
         hdr_status = '0;
         hdr_length = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_MAX_FRAME_LEN)
            max_len = data[FRAME_LEN_W-1:0];
         else if (idx == CSR_CAPR_BIAS)
            bias = data[CAPR_BIAS_W-1:0];
      endfunction

      function int unsigned payload_len();
         int unsigned p;
         p = (hdr_length > HEADER_BYTES) ? hdr_length - HEADER_BYTES : 0;
         if (p > max_len)
            p = max_len;
         return p;
      endfunction

      function void emit(kind_type k, logic [BYTE_W-1:0] d, int unsigned flen,
                         int unsigned rp);
         deframe_result_type r;
         r.kind = k;
         r.data_byte = d;
         r.frame_length = FRAME_LEN_W'(flen);
         r.read_pointer = READ_PTR_W'(rp);
         expected.push_back(r);
      endfunction

      // one accepted ring byte -> zero or one expected words
      function void note_ring_byte(logic [BYTE_W-1:0] b);
         int unsigned idx, end_off, total, new_off;
         if (halted)
            return;
         idx = byte_count;
         byte_count = idx + 1;
         if (phase == PARSE_HEADER) begin
            case (idx)
               HDR_STATUS_LO: hdr_status[7:0]  = b;
               HDR_STATUS_HI: hdr_status[15:8] = b;
               HDR_LENGTH_LO: hdr_length[7:0]  = b;
               HDR_LENGTH_HI: hdr_length[15:8] = b;
               default: ;
            endcase
            if (byte_count < HEADER_BYTES)
               return;
            if (hdr_length == 0 || hdr_length > RING_BYTES - HEADER_BYTES) begin
               halted = 1'b1;
               emit(KIND_LEN_INVALID, '0, 0, 0);
               return;
            end
            phase = hdr_status[0] ? PARSE_GOOD : PARSE_BAD;
            return;
         end
         end_off = (ring_off + hdr_length + FRAME_PAD) & ~32'd3;
         total = end_off - ring_off;
         if (byte_count >= total) begin
            new_off = end_off % RING_BYTES;
            ring_off = new_off;
            if (phase == PARSE_GOOD)
               emit(KIND_FRAME_GOOD, '0, payload_len(), new_off - bias);
            else
               emit(KIND_FRAME_BAD, '0, 0, new_off - bias);
            open_frame();
            return;
         end
         if (phase == PARSE_GOOD && idx >= HEADER_BYTES && idx < HEADER_BYTES + payload_len())
            emit(KIND_PAYLOAD, b, 0, 0);
      endfunction

      function void check_result(deframe_result_type got);
         deframe_result_type want;
         results_checked++;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected word kind=%0d data=%02h len=%0d rp=%04h", $realtime,
                        got.kind, got.data_byte, got.frame_length, got.read_pointer);
            return;
         end
         want = expected.pop_front();
         if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
             got.frame_length !== want.frame_length ||
             got.read_pointer !== want.read_pointer) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("%0t: word %0d want kind=%0d data=%02h len=%0d rp=%04h,",
                      $realtime, results_checked, want.kind, want.data_byte,
                      want.frame_length, want.read_pointer);
               $display(" got kind=%0d data=%02h len=%0d rp=%04h", got.kind,
                        got.data_byte, got.frame_length, got.read_pointer);
            end
         end
      endfunction

      function int unsigned pending();
         return expected.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   erd_req_if req_if ();
   erd_rsp_if rsp_if ();

   deframe_scoreboard sb;
   bit          idle_en;
   int unsigned bytes_sent;
   int unsigned bytes_taken;
   int unsigned frames_sent;
   int unsigned quiet_cycles;

   ethernet_rx_ring_deframer_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned idle_gap();
      int unsigned r;
      if (!idle_en)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic push_ring_byte(input logic [BYTE_W-1:0] b);
      int unsigned gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ring_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [LEN_W-1:0] status, input logic [LEN_W-1:0] flen);
      int unsigned total;
      push_ring_byte(status[7:0]);
      push_ring_byte(status[15:8]);
      push_ring_byte(flen[7:0]);
      push_ring_byte(flen[15:8]);
      // read offset always sits on a 4-byte boundary
      total = (flen + FRAME_PAD) & ~32'd3;
      for (int unsigned i = HEADER_BYTES; i < total; i++)
         push_ring_byte(BYTE_W'($urandom));
      frames_sent++;
   endtask

   task automatic send_random_frame();
      logic [LEN_W-1:0] status, flen;
      int unsigned r;
      status = LEN_W'($urandom);
      status[0] = ($urandom_range(0, 9) < 8);
      r = $urandom_range(0, 99);
      if (r < 70)
         flen = LEN_W'($urandom_range(1, 40));
      else if (r < 96)
         flen = LEN_W'($urandom_range(41, 200));
      else
         flen = LEN_W'($urandom_range(201, 400));
      send_frame(status, flen);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic set_regs(input logic [FRAME_LEN_W-1:0] max_len,
                           input logic [CAPR_BIAS_W-1:0] bias);
      logic [CSR_DATA_W-1:0] w;
      write_reg(CSR_MAX_FRAME_LEN, max_len);
      // junk above the bias field must be dropped
      w = CSR_DATA_W'($urandom);
      w[CAPR_BIAS_W-1:0] = bias;
      write_reg(CSR_CAPR_BIAS, w);
   endtask

   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // result side: random ready with the odd long hold-off so the input backs up
   initial begin : rsp_drive
      int unsigned on_cycles, off_cycles, next_hold_at;
      rsp_if.ready = 1'b0;
      next_hold_at = 150;
      wait (!reset);
      @(negedge clock);
      forever begin
         on_cycles = idle_en ? $urandom_range(1, 12) : 16;
         rsp_if.ready <= 1'b1;
         repeat (on_cycles) @(negedge clock);
         off_cycles = idle_gap();
         if (sb.results_checked >= next_hold_at) begin
            next_hold_at += 2500;
            off_cycles = LONG_HOLD;
         end
         if (off_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (off_cycles) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : monitor
      deframe_result_type got;
      bit                 moved;
      if (!reset) begin
         moved = 1'b0;
         // note the input first so a same-edge result still finds its expectation
         if (req_if.valid && req_if.ready) begin
            sb.note_ring_byte(req_if.ring_byte);
            bytes_taken++;
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind = rsp_if.kind;
            got.data_byte = rsp_if.data_byte;
            got.frame_length = rsp_if.frame_length;
            got.read_pointer = rsp_if.read_pointer;
            sb.check_result(got);
            moved = 1'b1;
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no handshake for %0d cycles, %0d words still expected",
                     quiet_cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [LEN_W-1:0] bad_len;
      int unsigned phase_start;
      sb = new();
      req_if.valid = 1'b0;
      req_if.ring_byte = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_en = 1'b0;
      bytes_sent = 0;
      bytes_taken = 0;
      frames_sent = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: shortest frames, bad status, pointer below bias, caps
      set_regs(MAX_FRAME_LEN_RESET, CAPR_BIAS_RESET);
      send_frame(16'h0001, 16'd1);
      send_frame(16'hFFFF, 16'd4);
      send_frame(16'h8001, 16'd5);
      send_frame(16'h0000, 16'd1);
      send_frame(16'hFFFE, 16'd64);
      send_frame(16'h0001, 16'h0123);
      idle_en = 1'b1;
      settle_block();
      set_regs(11'd10, 8'd200);
      send_frame(16'h0001, 16'd40);
      send_frame(16'h0003, 16'd14);
      send_frame(16'h0001, 16'd13);
      settle_block();
      set_regs(11'd0, 8'd0);
      send_frame(16'h0001, 16'd20);
      send_frame(16'h0000, 16'd20);
      settle_block();
      set_regs(11'd2047, 8'd255);
      send_frame(16'h0001, 16'd2);
      send_frame(16'h0001, 16'd3);
      send_frame(16'h0001, 16'd8);

      // random frames under several register settings
      for (int p = 0; p < 5; p++) begin
         settle_block();
         case (p)
            0: set_regs(FRAME_LEN_W'($urandom_range(0, 64)), CAPR_BIAS_W'($urandom));
            1: set_regs(11'd2047, 8'd0);
            2: set_regs(11'd0, 8'd255);
            3: set_regs(FRAME_LEN_W'($urandom), CAPR_BIAS_W'($urandom));
            default: set_regs(MAX_FRAME_LEN_RESET, CAPR_BIAS_RESET);
         endcase
         idle_en = (p != 1 && p != 3);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES)
            send_random_frame();
      end

      // invalid length halts the parser; the trailing bytes must be dropped
      settle_block();
      case ($urandom_range(0, 2))
         0: bad_len = '0;
         1: bad_len = LEN_W'(RING_BYTES - HEADER_BYTES + 1);
         default: bad_len = LEN_W'($urandom_range(RING_BYTES - HEADER_BYTES + 1, 65535));
      endcase
      push_ring_byte(BYTE_W'($urandom));
      push_ring_byte(BYTE_W'($urandom));
      push_ring_byte(bad_len[7:0]);
      push_ring_byte(bad_len[15:8]);
      repeat (8) push_ring_byte(BYTE_W'($urandom));
      req_if.valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Covered %0d ring bytes in %0d frames plus a length halt (length %0d).",
               bytes_taken, frames_sent, bad_len);
      $display("Checked %0d result words, %0d wrong, %0d never arrived.",
               sb.results_checked, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/erd_pkg.sv
hw/rtl/erd_req_if.sv
hw/rtl/erd_rsp_if.sv
hw/rtl/ethernet_rx_ring_deframer_unit.sv
bench/ethernet_rx_ring_deframer_unit_tb.sv
